/* src/swr_pkg.sv */
package swr_pkg;

  localparam int CFG_DATA_W = 64;
  localparam int LEN_W      = 4;

  typedef enum logic [1:0] {
    CFG_PATTERN_BYTES      = 2'd0,
    CFG_PATTERN_LENGTH     = 2'd1,
    CFG_REPLACEMENT_BYTES  = 2'd2,
    CFG_REPLACEMENT_LENGTH = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] pattern_bytes;
    logic [LEN_W-1:0]      pattern_length;
    logic [CFG_DATA_W-1:0] replacement_bytes;
    logic [LEN_W-1:0]      replacement_length;
  } cfg_t;

endpackage

/* src/swr_front.sv */
module swr_front #(
  parameter int MAX_WORD_BYTES = 8,
  parameter int JOB_W          = 69
) (
  input  logic               clk,
  input  logic               rst_n,
  input  swr_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_text_byte,
  input  logic               in_final_byte,
  input  logic               job_ready,
  output logic               job_push,
  output logic [JOB_W-1:0]   job_word
);
  import swr_pkg::*;

  localparam int DATA_W = MAX_WORD_BYTES * 8;
  localparam int CNT_W  = $clog2(MAX_WORD_BYTES + 1);
  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_WORD_BYTES);

  logic [7:0]       win_r   [MAX_WORD_BYTES];
  logic [7:0]       win_nxt [MAX_WORD_BYTES];
  logic [7:0]       w1      [MAX_WORD_BYTES];
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CNT_W-1:0] cnt1;
  logic [CNT_W-1:0] plen;
  logic [CNT_W-1:0] rlen;
  logic [CNT_W-1:0] keep;
  logic [CNT_W-1:0] emit;
  logic [CNT_W-1:0] job_cnt;
  logic [DATA_W-1:0] win_flat;
  logic [DATA_W-1:0] job_data;
  logic             over;
  logic             match;
  logic             hit;
  logic             accept;

  function automatic logic [CNT_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
    return (v > MaxLen) ? CNT_W'(MAX_WORD_BYTES) : CNT_W'(v);
  endfunction

  assign in_stall = !job_ready;
  assign accept   = in_valid && job_ready;

  always_comb begin
    plen = clamp_len(cfg.pattern_length);
    rlen = clamp_len(cfg.replacement_length);
    cnt1 = count_r + 1'b1;
    for (int i = 0; i < MAX_WORD_BYTES; i++) begin
      w1[i] = (CNT_W'(i) == count_r) ? in_text_byte : win_r[i];
      win_flat[8*i +: 8] = w1[i];
    end
    keep  = (plen == '0) ? '0 : plen - 1'b1;
    over  = (plen == '0) || (cnt1 > plen);
    match = 1'b1;
    for (int i = 0; i < MAX_WORD_BYTES; i++) begin
      if ((CNT_W'(i) < plen) && (w1[i] != cfg.pattern_bytes[8*i +: 8])) begin
        match = 1'b0;
      end
    end
    hit = !over && (cnt1 == plen) && match;
    if (in_final_byte) begin
      emit = cnt1;
    end else if (over) begin
      emit = cnt1 - keep;
    end else if ((cnt1 == plen) && !hit) begin
      emit = CNT_W'(1);
    end else begin
      emit = '0;
    end
    count_nxt = (hit || in_final_byte) ? '0 : cnt1 - emit;
    for (int i = 0; i < MAX_WORD_BYTES; i++) begin
      win_nxt[i] = '0;
      for (int k = 0; k <= MAX_WORD_BYTES; k++) begin
        if (i + k < MAX_WORD_BYTES) begin
          if (emit == CNT_W'(k)) begin
            win_nxt[i] = w1[i + k];
          end
        end
      end
    end
    job_data = hit ? cfg.replacement_bytes[DATA_W-1:0] : win_flat;
    job_cnt  = hit ? rlen : emit;
  end

  assign job_word = {in_final_byte, job_cnt, job_data};
  assign job_push = accept && ((job_cnt != '0) || in_final_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

endmodule

/* src/swr_queue.sv */
module swr_queue #(
  parameter int WIDTH = 69
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_word,
  output logic             not_full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] head_word
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       fill_r;
  logic             do_push;
  logic             do_pop;

  assign not_full  = (fill_r != 2'd2);
  assign not_empty = (fill_r != 2'd0);
  assign head_word = mem[rd_ptr_r];
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      fill_r <= fill_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_word;
    end
  end

endmodule

/* src/swr_back.sv */
module swr_back #(
  parameter int MAX_WORD_BYTES = 8,
  parameter int JOB_W          = 69
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  logic [JOB_W-1:0] head_word,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_result_byte,
  output logic             out_byte_present,
  output logic             out_run_end,
  output logic             out_stream_done
);

  localparam int DATA_W = MAX_WORD_BYTES * 8;
  localparam int CNT_W  = $clog2(MAX_WORD_BYTES + 1);

  logic              busy_r;
  logic [DATA_W-1:0] data_r;
  logic [CNT_W-1:0]  rem_r;
  logic              last_r;
  logic              bare_r;
  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic              out_present_r;
  logic              out_end_r;
  logic              out_done_r;
  logic              out_free;
  logic              finishing;
  logic              load;
  logic [DATA_W-1:0] head_data;
  logic [CNT_W-1:0]  head_cnt;
  logic              head_last;

  assign {head_last, head_cnt, head_data} = head_word;

  assign out_free  = !out_valid_r || !out_stall;
  assign finishing = busy_r && out_free && (rem_r == CNT_W'(1));
  assign load      = head_valid && (!busy_r || finishing);
  assign pop       = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_r <= busy_r;
      end
      if (load) begin
        busy_r <= 1'b1;
      end else if (finishing) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r && out_free) begin
      out_byte_r    <= bare_r ? 8'd0 : data_r[7:0];
      out_present_r <= !bare_r;
      out_end_r     <= (rem_r == CNT_W'(1));
      out_done_r    <= (rem_r == CNT_W'(1)) && last_r;
    end
    if (load) begin
      data_r <= head_data;
      rem_r  <= (head_cnt == '0) ? CNT_W'(1) : head_cnt;
      last_r <= head_last;
      bare_r <= (head_cnt == '0);
    end else if (busy_r && out_free) begin
      data_r <= data_r >> 8;
      rem_r  <= rem_r - 1'b1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_byte  = out_byte_r;
  assign out_byte_present = out_present_r;
  assign out_run_end      = out_end_r;
  assign out_stream_done  = out_done_r;

endmodule

/* src/stream_word_replacer_core.sv */
// channel | ports                                         | direction
// input   | in_valid, in_stall, in_text_byte, in_final_byte | into the block
// result  | out_valid, out_stall, out_result_byte,          | out of the block
//         | out_byte_present, out_run_end, out_stream_done  |
// config  | cfg_we, cfg_index, cfg_wdata                  | into the block, write only
//
// an item that yields at most one result: one item per cycle sustained while out_stall is low
// an item that yields n results holds the output side until all n are sent (n up to MAX_WORD_BYTES)
// a two-entry job queue between window logic and output serializer absorbs bursts
// results pass through the job queue, then the serializer's word register, then its output register
// synchronous active-low reset clears config, window count, queue and output valid
module stream_word_replacer_core #(
  parameter int MAX_WORD_BYTES = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  swr_pkg::cfg_idx_t                  cfg_index,
  input  logic [swr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_text_byte,
  input  logic                               in_final_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         out_result_byte,
  output logic                               out_byte_present,
  output logic                               out_run_end,
  output logic                               out_stream_done
);
  import swr_pkg::*;

  localparam int DATA_W = MAX_WORD_BYTES * 8;
  localparam int CNT_W  = $clog2(MAX_WORD_BYTES + 1);
  localparam int JOB_W  = DATA_W + CNT_W + 1;

  cfg_t             cfg_r;
  logic             job_push;
  logic [JOB_W-1:0] job_word;
  logic             q_not_full;
  logic             q_not_empty;
  logic [JOB_W-1:0] q_head;
  logic             q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PATTERN_BYTES:      cfg_r.pattern_bytes      <= cfg_wdata;
        CFG_PATTERN_LENGTH:     cfg_r.pattern_length     <= cfg_wdata[LEN_W-1:0];
        CFG_REPLACEMENT_BYTES:  cfg_r.replacement_bytes  <= cfg_wdata;
        CFG_REPLACEMENT_LENGTH: cfg_r.replacement_length <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  swr_front #(
    .MAX_WORD_BYTES(MAX_WORD_BYTES),
    .JOB_W         (JOB_W)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_text_byte (in_text_byte),
    .in_final_byte(in_final_byte),
    .job_ready    (q_not_full),
    .job_push     (job_push),
    .job_word     (job_word)
  );

  swr_queue #(
    .WIDTH(JOB_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_word(job_word),
    .not_full (q_not_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .head_word(q_head)
  );

  swr_back #(
    .MAX_WORD_BYTES(MAX_WORD_BYTES),
    .JOB_W         (JOB_W)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (q_not_empty),
    .head_word       (q_head),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_byte (out_result_byte),
    .out_byte_present(out_byte_present),
    .out_run_end     (out_run_end),
    .out_stream_done (out_stream_done)
  );

  a_done_has_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stream_done |-> out_run_end)
    else $error("stream end without run end");

  a_bare_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_present |-> out_stream_done && (out_result_byte == 8'd0))
    else $error("bare end marker not final or not zero");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import swr_pkg::*;

  localparam int WORD_BYTES     = 8;
  localparam int RANDOM_ITEMS   = 380;
  localparam int SETTLE_CYCLES  = 16;
  localparam int LONG_HOLD      = 200;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       item_last;
    logic       stream_last;
  } text_out_t;

  class replace_scoreboard;
    logic [CFG_DATA_W-1:0] pat_bytes;
    logic [CFG_DATA_W-1:0] rep_bytes;
    logic [LEN_W-1:0]      pat_len;
    logic [LEN_W-1:0]      rep_len;
    logic [7:0]            window [WORD_BYTES];
    int                    window_fill;
    text_out_t             due_q[$];
    int                    mismatches;

    function new();
      int i;
      pat_bytes = '0;
      rep_bytes = '0;
      pat_len = '0;
      rep_len = '0;
      for (i = 0; i < WORD_BYTES; i++) window[i] = '0;
      window_fill = 0;
      mismatches = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_PATTERN_BYTES:      pat_bytes = value;
        CFG_PATTERN_LENGTH:     pat_len = value[LEN_W-1:0];
        CFG_REPLACEMENT_BYTES:  rep_bytes = value;
        CFG_REPLACEMENT_LENGTH: rep_len = value[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void emit_oldest();
      int i;
      text_out_t res;
      if (window_fill == 0) return;
      res = {window[0], 1'b1, 1'b0, 1'b0};
      due_q.push_back(res);
      for (i = 0; i < WORD_BYTES - 1; i++) window[i] = window[i + 1];
      window[WORD_BYTES - 1] = '0;
      window_fill--;
    endfunction

    function void note_item(logic [7:0] text, logic last);
      int plen, rlen, keep, start, i;
      bit hit;
      text_out_t res;
      plen = (pat_len > WORD_BYTES) ? WORD_BYTES : int'(pat_len);
      rlen = (rep_len > WORD_BYTES) ? WORD_BYTES : int'(rep_len);
      start = due_q.size();
      if (window_fill >= WORD_BYTES) emit_oldest();
      window[window_fill] = text;
      window_fill++;
      if (plen == 0 || window_fill > plen) begin
        keep = (plen == 0) ? 0 : plen - 1;
        while (window_fill > keep) emit_oldest();
      end else if (window_fill == plen) begin
        hit = 1'b1;
        for (i = 0; i < plen; i++) begin
          if (window[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
        end
        if (hit) begin
          for (i = 0; i < rlen; i++) begin
            res = {rep_bytes[8*i +: 8], 1'b1, 1'b0, 1'b0};
            due_q.push_back(res);
          end
          for (i = 0; i < WORD_BYTES; i++) window[i] = '0;
          window_fill = 0;
        end else begin
          emit_oldest();
        end
      end
      if (last) begin
        while (window_fill > 0) emit_oldest();
        if (due_q.size() == start) begin
          res = {8'h00, 1'b0, 1'b0, 1'b0};
          due_q.push_back(res);
        end
      end
      if (due_q.size() > start) begin
        due_q[due_q.size() - 1].item_last = 1'b1;
        if (last) due_q[due_q.size() - 1].stream_last = 1'b1;
      end
    endfunction

    function void check_out(text_out_t got);
      text_out_t want;
      if (due_q.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: byte %h present %b run_end %b done %b",
                   got.data, got.present, got.item_last, got.stream_last);
        mismatches++;
        return;
      end
      want = due_q.pop_front();
      if (got.data !== want.data || got.present !== want.present ||
          got.item_last !== want.item_last || got.stream_last !== want.stream_last) begin
        if (mismatches < 10)
          $display("mismatch: expected byte %h present %b run_end %b done %b, got %h %b %b %b",
                   want.data, want.present, want.item_last, want.stream_last,
                   got.data, got.present, got.item_last, got.stream_last);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            in_text_byte;
  logic                  in_final_byte;
  logic                  out_valid;
  logic                  out_stall;
  logic [7:0]            out_result_byte;
  logic                  out_byte_present;
  logic                  out_run_end;
  logic                  out_stream_done;

  replace_scoreboard sb;
  logic [7:0]        text_q[$];
  bit                quiet;
  bit                hold_req;
  int                idle_cycles;

  stream_word_replacer_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_text_byte     (in_text_byte),
    .in_final_byte    (in_final_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_byte  (out_result_byte),
    .out_byte_present (out_byte_present),
    .out_run_end      (out_run_end),
    .out_stream_done  (out_stream_done)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_item(in_text_byte, in_final_byte);
      if (out_valid && !out_stall)
        sb.check_out({out_result_byte, out_byte_present, out_run_end, out_stream_done});
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL stream_word_replacer_core");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int idle_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // receiver side stalls
  initial begin
    int n;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        n = LONG_HOLD;
      end else begin
        n = idle_len();
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat (1 + idle_len()) @(posedge clk);
    end
  end

  task automatic send_byte(logic [7:0] text, logic last);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_text_byte  <= text;
    in_final_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_text(bit closes);
    foreach (text_q[k]) send_byte(text_q[k], closes && (k == text_q.size() - 1));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.due_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  task automatic load_config(logic [63:0] pb, logic [63:0] pl, logic [63:0] rb,
                             logic [63:0] rl);
    settle();
    write_reg(CFG_PATTERN_BYTES, pb);
    write_reg(CFG_PATTERN_LENGTH, pl);
    write_reg(CFG_REPLACEMENT_BYTES, rb);
    write_reg(CFG_REPLACEMENT_LENGTH, rl);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int rand_sent, phase, plen, rlen, len, n_streams, r, i, s, k;
    logic [63:0] pat, rep, plw, rlw;
    logic [7:0]  alpha [3];
    bit closes;

    sb = new();
    quiet = 1'b0;
    hold_req = 1'b0;
    idle_cycles = 0;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_PATTERN_BYTES;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    in_text_byte  <= '0;
    in_final_byte <= 1'b0;
    out_stall     <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pass through after reset
    text_q = '{8'h00, 8'hFF};
    send_text(1'b1);
    // two-byte pattern, longer replacement, false start before the match
    load_config(64'h6261, 64'd2, 64'h5A5958, 64'd3);
    text_q = '{8'h61, 8'h61, 8'h62, 8'h63};
    send_text(1'b1);
    // oversized lengths saturate, match on the last byte
    load_config('1, 64'd15, 64'h0123_4567_89AB_CDEF, 64'd12);
    text_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_text(1'b1);
    // pattern shrunk while the window holds bytes, empty replacement
    text_q = '{8'hFF, 8'hFF, 8'hFF, 8'h11};
    send_text(1'b0);
    load_config(64'h2211, 64'd2, 64'h0, 64'd0);
    text_q = '{8'h22};
    send_text(1'b1);
    text_q = '{8'h11, 8'h22};
    send_text(1'b1);

    rand_sent = 0;
    phase = 0;
    while (rand_sent < RANDOM_ITEMS) begin
      phase++;
      for (i = 0; i < 3; i++) alpha[i] = $urandom_range(0, 255);
      r = $urandom_range(0, 9);
      if (r == 0) plen = 0;
      else if (r == 8) plen = $urandom_range(9, 15);
      else if (r == 9) plen = 8;
      else plen = $urandom_range(1, 8);
      rlen = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 8) : $urandom_range(9, 15);
      if ($urandom_range(0, 3) == 0) begin
        pat = {$urandom, $urandom};
      end else begin
        for (i = 0; i < 8; i++) pat[8*i +: 8] = alpha[$urandom_range(0, 2)];
      end
      rep = {$urandom, $urandom};
      plw = {$urandom, $urandom};
      plw[3:0] = plen[3:0];
      rlw = {$urandom, $urandom};
      rlw[3:0] = rlen[3:0];
      load_config(pat, plw, rep, rlw);
      if (plen > WORD_BYTES) plen = WORD_BYTES;
      quiet = ($urandom_range(0, 4) == 0);
      if (phase == 3) begin
        quiet = 1'b1;
        hold_req = 1'b1;
        // start sending only once the receiver has begun its long hold
        wait (hold_req == 1'b0);
      end
      n_streams = $urandom_range(1, 3);
      for (s = 0; s < n_streams; s++) begin
        if (phase == 3) len = 40;
        else if ($urandom_range(0, 4) == 0) len = $urandom_range(15, 40);
        else len = $urandom_range(1, 12);
        text_q = {};
        while (text_q.size() < len) begin
          r = $urandom_range(0, 99);
          if (r < 40 && plen > 0) begin
            for (i = 0; i < plen; i++) text_q.push_back(pat[8*i +: 8]);
          end else if (r < 50 && plen > 1) begin
            k = $urandom_range(1, plen - 1);
            for (i = 0; i < k; i++) text_q.push_back(pat[8*i +: 8]);
          end else if (r < 95) begin
            text_q.push_back(alpha[$urandom_range(0, 2)]);
          end else begin
            text_q.push_back($urandom_range(0, 255));
          end
        end
        closes = (s < n_streams - 1) || ($urandom_range(0, 3) != 0);
        send_text(closes);
        rand_sent += text_q.size();
      end
    end

    settle();
    repeat (30) @(posedge clk);
    if (sb.mismatches == 0 && sb.due_q.size() == 0) begin
      $display("PASS stream_word_replacer_core");
    end else begin
      $display("FAIL stream_word_replacer_core");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/swr_pkg.sv
src/swr_front.sv
src/swr_queue.sv
src/swr_back.sv
src/stream_word_replacer_core.sv
bench/tb_top.sv
